[hw/rtl/pidl_pkg.sv]
`default_nettype none
package pidl_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               last;
  } rsp_t;

  // per-cycle command broadcast along the chain
  typedef struct packed {
    logic               ld_new;
    logic               shift_dn;
    logic               rotate;
    logic [7:0]         pos;
    logic [7:0]         count;
    logic signed [31:0] value;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/pidl_cell.sv]
`default_nettype none
module pidl_cell
  import pidl_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  wire logic               clk,
  input  wire cmd_t               cmd,
  input  wire logic signed [31:0] left,
  input  wire logic signed [31:0] right,
  input  wire logic signed [31:0] head,
  output logic signed [31:0]      value
);

  localparam logic [7:0] IDX = 8'(INDEX);

  logic signed [31:0] value_next;
  logic [7:0]         top;

  assign top = cmd.count - 8'd1;

  always_comb begin
    value_next = value;
    if (cmd.ld_new) begin
      if (IDX == cmd.pos) begin
        value_next = cmd.value;
      end else if (IDX > cmd.pos && IDX <= cmd.count) begin
        value_next = left;
      end
    end else if (cmd.shift_dn) begin
      if (IDX >= cmd.pos && IDX < top) begin
        value_next = right;
      end
    end else if (cmd.rotate) begin
      if (IDX == top) begin
        value_next = head;
      end else if (IDX < top) begin
        value_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

[hw/rtl/positional_insert_delete_list.sv]
`default_nettype none
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+----------------------------
// request  | req_valid | req_stall | req  (kind, position, value)
// response | rsp_valid | rsp_stall | rsp  (element, last)
//
// insert and delete shift the cells in place; clear only zeroes the count
// read-out rotates the occupied cells toward cell 0, which feeds the output
// register, once per stored element (held by rsp_stall); the list ends restored
// req_stall is high for the whole read-out; an empty read-out gives nothing
// rst (synchronous) clears the element count and the response valid
module positional_insert_delete_list
  import pidl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      remaining, remaining_next;
  logic               accept, step, full, pos_ge;
  logic [7:0]         clamped;
  cmd_t               cmd;
  logic signed [31:0] cells [CAPACITY];

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign step      = (state == ST_READ) && (!rsp_valid || !rsp_stall);
  assign full      = (count == CW'(CAPACITY));
  assign pos_ge    = (req.position >= 8'(count));
  assign clamped   = pos_ge ? 8'(count) : req.position;

  always_comb begin
    cmd            = '0;
    cmd.pos        = clamped;
    cmd.count      = 8'(count);
    cmd.value      = req.value;
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    if (accept) begin
      case (req.kind)
        KIND_INSERT: begin
          if (!full) begin
            cmd.ld_new = 1'b1;
            count_next = count + CW'(1);
          end
        end
        KIND_DELETE: begin
          if (!pos_ge) begin
            cmd.shift_dn = 1'b1;
            count_next   = count - CW'(1);
          end
        end
        KIND_CLEAR: begin
          count_next = '0;
        end
        KIND_READ: begin
          if (count != '0) begin
            state_next     = ST_READ;
            remaining_next = count;
          end
        end
        default: begin
          state_next = state;
        end
      endcase
    end else if (step) begin
      cmd.rotate     = 1'b1;
      remaining_next = remaining - CW'(1);
      if (remaining == CW'(1)) begin
        state_next = ST_IDLE;
      end
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [31:0] left, right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cells[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cells[k+1];
    end
    pidl_cell #(
      .INDEX(k)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .left (left),
      .right(right),
      .head (cells[0]),
      .value(cells[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (step) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp.element <= cells[0];
      rsp.last    <= (remaining == CW'(1));
    end
  end

endmodule
`default_nettype wire
